>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define BTPC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition in one cycle implies a result in the next
`define BTPC_ASSERT_NEXT(label, pre, post, msg) \
	`BTPC_ASSERT(label, (pre) |=> (post), msg)

`endif

>>> rtl/btpc_pkg.sv
// ----------------------------------------------------------------------------
// btpc_pkg
// types, constants and multiply helpers for the compensation pipeline
// ----------------------------------------------------------------------------
package btpc_pkg;

	localparam int RAW_W       = 20;
	localparam int CAL_W       = 48;
	localparam int CFG_IDX_W   = 2;
	localparam int FIFO_DEPTH  = 4;
	localparam int DIV_STEPS   = 64;

	localparam int T_FINE_OFFSET = 128000;
	localparam int P_FULL_SCALE  = 1048576;
	localparam int P_SCALE       = 3125;
	localparam int TEMP_ROUND    = 128;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAL_TEMP,
		REG_CAL_PRESS_FIRST,
		REG_CAL_PRESS_MIDDLE,
		REG_CAL_PRESS_LAST
	} cfg_reg_t;

	// temperature result plus raw pressure, front to back
	typedef struct packed {
		logic [31:0]      temp;
		logic [31:0]      fine;
		logic [RAW_W-1:0] adc_p;
	} temp_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	// partial products of a 64 x 64 product, low 64 bits
	typedef struct packed {
		logic [63:0] pp0;
		logic [31:0] pp1;
		logic [31:0] pp2;
	} mul_pp_t;

	// partial products of a 64 x 17 signed product, low 64 bits
	typedef struct packed {
		logic [63:0] lo;
		logic [31:0] hi;
	} mul_ps_t;

	function automatic logic [63:0] sext16(input logic [15:0] w);
		return {{48{w[15]}}, w};
	endfunction

	function automatic logic [16:0] coef_s(input logic [15:0] w);
		return {w[15], w};
	endfunction

	function automatic logic [16:0] coef_u(input logic [15:0] w);
		return {1'b0, w};
	endfunction

	function automatic mul_pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
		mul_pp_t r;
		r.pp0 = a[31:0] * b[31:0];
		r.pp1 = a[31:0] * b[63:32];
		r.pp2 = a[63:32] * b[31:0];
		return r;
	endfunction

	function automatic logic [63:0] mul_pp_sum(input mul_pp_t r);
		return r.pp0 + {r.pp1 + r.pp2, 32'b0};
	endfunction

	function automatic mul_ps_t mul_ps(input logic [63:0] a, input logic [16:0] b);
		logic signed [49:0] lo_full;
		mul_ps_t r;
		lo_full = $signed({1'b0, a[31:0]}) * $signed(b);
		r.lo = {{14{lo_full[49]}}, lo_full};
		r.hi = a[63:32] * {{15{b[16]}}, b};
		return r;
	endfunction

	function automatic logic [63:0] mul_ps_sum(input mul_ps_t r);
		return r.lo + {r.hi, 32'b0};
	endfunction

endpackage

>>> rtl/btpc_front.sv
// ----------------------------------------------------------------------------
// btpc_front
// accepts raw sample pairs and computes fine and centi-degree temperature
// ----------------------------------------------------------------------------
module btpc_front import btpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [RAW_W-1:0]   raw_temperature,
	input  logic [RAW_W-1:0]   raw_pressure,
	input  logic [CAL_W-1:0]   cal_temp,
	input  fifo_status_t       fifo_status,
	output logic               push,
	output temp_item_t         push_item
);

	logic [31:0] t1, t2, t3;
	logic        adv;
	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [31:0] x_s1, d_s1, ax_s2, dd_s2, a_s3, bm_s3, fine_s4, fine_s5, temp_s5;
	logic [RAW_W-1:0] p_s1, p_s2, p_s3, p_s4, p_s5;
	logic [31:0] dd_sh, round_sum;

	assign t1 = {16'b0, cal_temp[15:0]};
	assign t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
	assign t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};

	// whole front moves together, held only when the queue cannot take the tail
	assign adv      = !(v_s5 && fifo_status.full);
	assign in_stall = !adv;

	assign dd_sh     = $signed(dd_s2) >>> 12;
	assign round_sum = fine_s4 * 32'd5 + 32'(TEMP_ROUND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= {15'b0, raw_temperature[19:3]} - {15'b0, t1[15:0], 1'b0};
			d_s1    <= {16'b0, raw_temperature[19:4]} - t1;
			p_s1    <= raw_pressure;
			ax_s2   <= x_s1 * t2;
			dd_s2   <= d_s1 * d_s1;
			p_s2    <= p_s1;
			a_s3    <= $signed(ax_s2) >>> 11;
			bm_s3   <= dd_sh * t3;
			p_s3    <= p_s2;
			fine_s4 <= $signed(a_s3) + ($signed(bm_s3) >>> 14);
			p_s4    <= p_s3;
			fine_s5 <= fine_s4;
			temp_s5 <= $signed(round_sum) >>> 8;
			p_s5    <= p_s4;
		end
	end

	assign push           = v_s5 && !fifo_status.full;
	assign push_item.temp = temp_s5;
	assign push_item.fine = fine_s5;
	assign push_item.adc_p = p_s5;

endmodule

>>> rtl/btpc_fifo.sv
// ----------------------------------------------------------------------------
// btpc_fifo
// short queue between the temperature front and the pressure back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module btpc_fifo import btpc_pkg::*; #(
	parameter int Depth = FIFO_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  temp_item_t   push_item,
	input  logic         pop,
	output temp_item_t   pop_item,
	output fifo_status_t status
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	temp_item_t      mem [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign status.full  = (count_q == CntW'(Depth));
	assign status.empty = (count_q == '0);
	assign pop_item     = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	`BTPC_ASSERT(a_no_overflow, push |-> !status.full, "push into full queue")
	`BTPC_ASSERT(a_no_underflow, pop |-> !status.empty, "pop from empty queue")
	`BTPC_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "count lost a push")

endmodule

>>> rtl/btpc_back.sv
// ----------------------------------------------------------------------------
// btpc_back
// pressure pipeline: polynomial terms, 64-step divider, final correction
// ----------------------------------------------------------------------------
module btpc_back import btpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  fifo_status_t     fifo_status,
	input  temp_item_t       q_item,
	output logic             pop,
	input  logic [CAL_W-1:0] cal_press_first,
	input  logic [CAL_W-1:0] cal_press_middle,
	input  logic [CAL_W-1:0] cal_press_last,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [31:0]      temperature_centi,
	output logic [31:0]      fine_temperature,
	output logic [31:0]      pressure_q24_8,
	output logic             pressure_invalid
);

	localparam logic [63:0] W_BIAS = 64'd1 << 47;

	typedef struct packed {
		logic [31:0] temp;
		logic [31:0] fine;
	} tf_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [63:0] dq;
		logic [30:0] mb;
		logic        neg;
		logic        inv;
		tf_t         tf;
	} div_stage_t;

	logic adv;
	logic out_valid_q;

	// stage valids before and after the divider
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic v_s10, v_s11, v_s12, v_s13, v_s14, v_s15;
	logic [DIV_STEPS-1:0] dvv_s;
	div_stage_t         dv_s [DIV_STEPS+1];

	tf_t         tf_s1, tf_s2, tf_s3, tf_s4, tf_s5, tf_s6, tf_s7, tf_s8;
	logic [20:0] dp_s1, dp_s2, dp_s3, dp_s4, dp_s5;
	logic [63:0] v1_s1;
	mul_pp_t     sq_s2;
	mul_ps_t     m5p_s2, m2p_s2;
	logic [63:0] sq_s3, m5_s3, m2_s3, m5_s4, m2_s4;
	mul_ps_t     x6_s4, x3_s4;
	logic [63:0] v2_s5, v1a_s5, w_s6, n0_s6;
	mul_ps_t     yp_s7, np_s7;
	logic [63:0] y_s8, num_s8;

	logic [63:0] dvsr, num_mag;

	tf_t         tf_s10, tf_s11, tf_s12, tf_s13, tf_s14, tf_s15;
	logic        inv_s10, inv_s11, inv_s12, inv_s13, inv_s14, inv_s15;
	logic [63:0] p_s10, q_s10, p_s11, p_s12, p_s13, p_s14;
	mul_pp_t     qq_s11;
	mul_ps_t     e8_s11, r9_s13;
	logic [63:0] qq_s12, e8_s12, v2c_s13, v2c_s14, v1c_s14, res_s15;
	logic [63:0] sum_fin, p_fix;

	logic [31:0] temp_q, fine_q, press_q;
	logic        inv_q;

	assign adv = !(out_valid_q && out_stall);
	assign pop = !fifo_status.empty && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			dvv_s <= '0;
			v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0;
			v_s13 <= 1'b0; v_s14 <= 1'b0; v_s15 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
			dvv_s <= {dvv_s[DIV_STEPS-2:0], v_s8};
			v_s10 <= dvv_s[DIV_STEPS-1];
			v_s11 <= v_s10; v_s12 <= v_s11; v_s13 <= v_s12;
			v_s14 <= v_s13; v_s15 <= v_s14;
			out_valid_q <= v_s15;
		end
	end

	// polynomial terms ahead of the divider
	always_ff @(posedge clk) begin
		if (adv) begin
			tf_s1  <= '{temp: q_item.temp, fine: q_item.fine};
			v1_s1  <= {{32{q_item.fine[31]}}, q_item.fine} - 64'(T_FINE_OFFSET);
			dp_s1  <= 21'(P_FULL_SCALE) - {1'b0, q_item.adc_p};

			tf_s2  <= tf_s1;
			dp_s2  <= dp_s1;
			sq_s2  <= mul_pp(v1_s1, v1_s1);
			m5p_s2 <= mul_ps(v1_s1, coef_s(cal_press_middle[31:16]));
			m2p_s2 <= mul_ps(v1_s1, coef_s(cal_press_first[31:16]));

			tf_s3  <= tf_s2;
			dp_s3  <= dp_s2;
			sq_s3  <= mul_pp_sum(sq_s2);
			m5_s3  <= mul_ps_sum(m5p_s2);
			m2_s3  <= mul_ps_sum(m2p_s2);

			tf_s4  <= tf_s3;
			dp_s4  <= dp_s3;
			x6_s4  <= mul_ps(sq_s3, coef_s(cal_press_middle[47:32]));
			x3_s4  <= mul_ps(sq_s3, coef_s(cal_press_first[47:32]));
			m5_s4  <= m5_s3;
			m2_s4  <= m2_s3;

			tf_s5  <= tf_s4;
			dp_s5  <= dp_s4;
			v2_s5  <= mul_ps_sum(x6_s4) + (m5_s4 << 17)
				+ (sext16(cal_press_middle[15:0]) << 35);
			v1a_s5 <= ($signed(mul_ps_sum(x3_s4)) >>> 8) + $signed(m2_s4 << 12);

			tf_s6  <= tf_s5;
			w_s6   <= W_BIAS + v1a_s5;
			n0_s6  <= {12'b0, dp_s5, 31'b0} - v2_s5;

			tf_s7  <= tf_s6;
			yp_s7  <= mul_ps(w_s6, coef_u(cal_press_first[15:0]));
			np_s7  <= mul_ps(n0_s6, 17'(P_SCALE));

			tf_s8  <= tf_s7;
			y_s8   <= mul_ps_sum(yp_s7);
			num_s8 <= mul_ps_sum(np_s7);
		end
	end

	// divider setup: magnitudes and result sign
	assign dvsr    = $signed(y_s8) >>> 33;
	assign num_mag = num_s8[63] ? (64'd0 - num_s8) : num_s8;

	always_comb begin
		dv_s[0].rem = '0;
		dv_s[0].dq  = num_mag;
		dv_s[0].mb  = dvsr[63] ? 31'(64'd0 - dvsr) : dvsr[30:0];
		dv_s[0].neg = num_s8[63] ^ dvsr[63];
		dv_s[0].inv = (dvsr == '0);
		dv_s[0].tf  = tf_s8;
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [31:0] trial;
		logic        ge;

		assign trial = {dv_s[k].rem[30:0], dv_s[k].dq[63]};
		assign ge    = (trial >= {1'b0, dv_s[k].mb});

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[k+1].rem <= ge ? trial - {1'b0, dv_s[k].mb} : trial;
				dv_s[k+1].dq  <= {dv_s[k].dq[62:0], ge};
				dv_s[k+1].mb  <= dv_s[k].mb;
				dv_s[k+1].neg <= dv_s[k].neg;
				dv_s[k+1].inv <= dv_s[k].inv;
				dv_s[k+1].tf  <= dv_s[k].tf;
			end
		end
	end

	assign p_fix   = dv_s[DIV_STEPS].neg ? (64'd0 - dv_s[DIV_STEPS].dq) : dv_s[DIV_STEPS].dq;
	assign sum_fin = p_s14 + v1c_s14 + v2c_s14;

	// correction terms after the divider
	always_ff @(posedge clk) begin
		if (adv) begin
			tf_s10  <= dv_s[DIV_STEPS].tf;
			inv_s10 <= dv_s[DIV_STEPS].inv;
			p_s10   <= p_fix;
			q_s10   <= $signed(p_fix) >>> 13;

			tf_s11  <= tf_s10;
			inv_s11 <= inv_s10;
			p_s11   <= p_s10;
			qq_s11  <= mul_pp(q_s10, q_s10);
			e8_s11  <= mul_ps(p_s10, coef_s(cal_press_last[31:16]));

			tf_s12  <= tf_s11;
			inv_s12 <= inv_s11;
			p_s12   <= p_s11;
			qq_s12  <= mul_pp_sum(qq_s11);
			e8_s12  <= mul_ps_sum(e8_s11);

			tf_s13  <= tf_s12;
			inv_s13 <= inv_s12;
			p_s13   <= p_s12;
			r9_s13  <= mul_ps(qq_s12, coef_s(cal_press_last[47:32]));
			v2c_s13 <= $signed(e8_s12) >>> 19;

			tf_s14  <= tf_s13;
			inv_s14 <= inv_s13;
			p_s14   <= p_s13;
			v1c_s14 <= $signed(mul_ps_sum(r9_s13)) >>> 25;
			v2c_s14 <= v2c_s13;

			tf_s15  <= tf_s14;
			inv_s15 <= inv_s14;
			res_s15 <= ($signed(sum_fin) >>> 8) + $signed(sext16(cal_press_last[15:0]) << 4);

			temp_q  <= tf_s15.temp;
			fine_q  <= tf_s15.fine;
			press_q <= inv_s15 ? 32'd0 : res_s15[31:0];
			inv_q   <= inv_s15;
		end
	end

	assign out_valid         = out_valid_q;
	assign temperature_centi = temp_q;
	assign fine_temperature  = fine_q;
	assign pressure_q24_8    = press_q;
	assign pressure_invalid  = inv_q;

endmodule

>>> rtl/baro_temp_press_compensation.sv
// ----------------------------------------------------------------------------
// baro_temp_press_compensation
// pipelined temperature and pressure compensation of raw sensor pairs
// ----------------------------------------------------------------------------
// usage:
//   write the four calibration registers through cfg_we / cfg_index / cfg_data
//   while nothing is in flight; each holds three 16-bit words in bits 47:0
//   input channel: in_valid / in_stall with raw_temperature and raw_pressure;
//   a request is taken at a clock edge with in_valid high and in_stall low
//   output channel: out_valid / out_stall with the compensated temperature,
//   fine temperature, Q24.8 pressure and the zero-divisor flag
// throughput: one request per cycle, sustained while out_stall stays low
// path: front stages, the queue, the multiply stages, the 64-stage radix-2
//   divider, the correction stages and the output register
// reset: arst_n clears all valids, the queue and the calibration registers
// stall: out_stall with out_valid high freezes the back pipeline; the front keeps filling the
//   queue until it is full, then in_stall rises
// ----------------------------------------------------------------------------
module baro_temp_press_compensation import btpc_pkg::*; #(
	parameter int FifoDepth = FIFO_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [RAW_W-1:0]     raw_temperature,
	input  logic [RAW_W-1:0]     raw_pressure,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   temperature_centi,
	output logic signed [31:0]   fine_temperature,
	output logic [31:0]          pressure_q24_8,
	output logic                 pressure_invalid,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAL_W-1:0]     cfg_data
);

	// calibration words
	logic [CAL_W-1:0] cal_temp_q;
	logic [CAL_W-1:0] cal_press_first_q;
	logic [CAL_W-1:0] cal_press_middle_q;
	logic [CAL_W-1:0] cal_press_last_q;

	// front to queue to back
	logic         push, pop;
	temp_item_t   push_item, pop_item;
	fifo_status_t fifo_status;

	logic [31:0]  temp_w, fine_w;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_temp_q         <= '0;
			cal_press_first_q  <= '0;
			cal_press_middle_q <= '0;
			cal_press_last_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CAL_TEMP:         cal_temp_q         <= cfg_data;
				REG_CAL_PRESS_FIRST:  cal_press_first_q  <= cfg_data;
				REG_CAL_PRESS_MIDDLE: cal_press_middle_q <= cfg_data;
				REG_CAL_PRESS_LAST:   cal_press_last_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: accept and compute the 32-bit temperature path
	btpc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.raw_temperature (raw_temperature),
		.raw_pressure    (raw_pressure),
		.cal_temp        (cal_temp_q),
		.fifo_status     (fifo_status),
		.push            (push),
		.push_item       (push_item)
	);

	// queue decouples the two stall domains
	btpc_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.status    (fifo_status)
	);

	// back: 64-bit pressure path with the divider, output register at its end
	btpc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.fifo_status       (fifo_status),
		.q_item            (pop_item),
		.pop               (pop),
		.cal_press_first   (cal_press_first_q),
		.cal_press_middle  (cal_press_middle_q),
		.cal_press_last    (cal_press_last_q),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.temperature_centi (temp_w),
		.fine_temperature  (fine_w),
		.pressure_q24_8    (pressure_q24_8),
		.pressure_invalid  (pressure_invalid)
	);

	assign temperature_centi = $signed(temp_w);
	assign fine_temperature  = $signed(fine_w);

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the compensation pipeline: requests with random gaps and stalls,
// results predicted in the bench and compared field by field in order
// ----------------------------------------------------------------------------
module tb_top;
	import btpc_pkg::*;

	typedef struct {
		logic signed [31:0] temp;
		logic signed [31:0] fine;
		logic [31:0]        press;
		logic               inval;
	} comp_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [RAW_W-1:0]     raw_temperature;
	logic [RAW_W-1:0]     raw_pressure;
	logic                 out_valid;
	logic                 out_stall;
	logic signed [31:0]   temperature_centi;
	logic signed [31:0]   fine_temperature;
	logic [31:0]          pressure_q24_8;
	logic                 pressure_invalid;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CAL_W-1:0]     cfg_data;

	// bench copy of the calibration registers
	logic [47:0]  cal_words [4];
	comp_result_t expected_q [$];
	int           errors;
	int           idle_cycles;
	bit           gaps_on;
	bit           hold_go;
	bit           hold_go_q;
	int           hold_left;

	baro_temp_press_compensation dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// predictor of one result
	function automatic comp_result_t compensate(logic [19:0] adc_t, logic [19:0] adc_p);
		comp_result_t r;
		logic signed [31:0] t1, t2, t3, a, d, b, fine;
		logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic signed [63:0] v1, v2, p, q, num;
		t1 = {16'b0, cal_words[REG_CAL_TEMP][15:0]};
		t2 = {{16{cal_words[REG_CAL_TEMP][31]}}, cal_words[REG_CAL_TEMP][31:16]};
		t3 = {{16{cal_words[REG_CAL_TEMP][47]}}, cal_words[REG_CAL_TEMP][47:32]};
		a = ((($signed({12'b0, adc_t}) >>> 3) - (t1 <<< 1)) * t2) >>> 11;
		d = ($signed({12'b0, adc_t}) >>> 4) - t1;
		b = (((d * d) >>> 12) * t3) >>> 14;
		fine = a + b;
		r.fine = fine;
		r.temp = (fine * 32'sd5 + 32'sd128) >>> 8;
		p1 = {48'b0, cal_words[REG_CAL_PRESS_FIRST][15:0]};
		p2 = {{48{cal_words[REG_CAL_PRESS_FIRST][31]}}, cal_words[REG_CAL_PRESS_FIRST][31:16]};
		p3 = {{48{cal_words[REG_CAL_PRESS_FIRST][47]}}, cal_words[REG_CAL_PRESS_FIRST][47:32]};
		p4 = {{48{cal_words[REG_CAL_PRESS_MIDDLE][15]}}, cal_words[REG_CAL_PRESS_MIDDLE][15:0]};
		p5 = {{48{cal_words[REG_CAL_PRESS_MIDDLE][31]}}, cal_words[REG_CAL_PRESS_MIDDLE][31:16]};
		p6 = {{48{cal_words[REG_CAL_PRESS_MIDDLE][47]}}, cal_words[REG_CAL_PRESS_MIDDLE][47:32]};
		p7 = {{48{cal_words[REG_CAL_PRESS_LAST][15]}}, cal_words[REG_CAL_PRESS_LAST][15:0]};
		p8 = {{48{cal_words[REG_CAL_PRESS_LAST][31]}}, cal_words[REG_CAL_PRESS_LAST][31:16]};
		p9 = {{48{cal_words[REG_CAL_PRESS_LAST][47]}}, cal_words[REG_CAL_PRESS_LAST][47:32]};
		v1 = 64'(fine) - 64'sd128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) <<< 17);
		v2 = v2 + (p4 <<< 35);
		v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
		v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
		r.press = '0;
		r.inval = (v1 == 0);
		if (!r.inval) begin
			p = 64'sd1048576 - $signed({44'b0, adc_p});
			num = ((p <<< 31) - v2) * 64'sd3125;
			// most negative over minus one wraps
			if (num == {1'b1, 63'b0} && v1 == -64'sd1)
				p = num;
			else
				p = num / v1;
			q = p >>> 13;
			v1 = (p9 * q * q) >>> 25;
			v2 = (p8 * p) >>> 19;
			p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
			r.press = p[31:0];
		end
		return r;
	endfunction

	// one register write while the pipeline is empty
	task automatic write_cal(cfg_reg_t idx, logic [47:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		cal_words[idx] = value;
		@(negedge clk);
	endtask

	task automatic write_all_cal(logic [47:0] w0, w1, w2, w3);
		write_cal(REG_CAL_TEMP, w0);
		write_cal(REG_CAL_PRESS_FIRST, w1);
		write_cal(REG_CAL_PRESS_MIDDLE, w2);
		write_cal(REG_CAL_PRESS_LAST, w3);
		cfg_we <= 1'b0;
	endtask

	// offer one request and hold it until taken
	task automatic send_pair(logic [19:0] adc_t, logic [19:0] adc_p);
		while (gaps_on && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid        <= 1'b1;
		raw_temperature <= adc_t;
		raw_pressure    <= adc_p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_q.push_back(compensate(adc_t, adc_p));
		@(negedge clk);
	endtask

	// wait until the pipeline has drained
	task automatic drain;
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	function automatic logic [47:0] rand_cal;
		return 48'({$urandom, $urandom});
	endfunction

	// typical sensor calibration, real-looking readings
	task automatic test_typical;
		write_all_cal({16'hFC18, 16'h6A80, 16'h6E3C}, {16'h0BB8, 16'hD6A0, 16'h9470},
			{16'hFFF9, 16'h0082, 16'h2AF0}, {16'h1770, 16'hC3B4, 16'h0F00});
		send_pair(20'h7E000, 20'h65000);
		send_pair(20'h80000, 20'h60000);
		send_pair(20'h00000, 20'h00000);
		send_pair(20'hFFFFF, 20'hFFFFF);
		send_pair(20'h00000, 20'hFFFFF);
		send_pair(20'hFFFFF, 20'h00000);
		drain();
	endtask

	// all-zero calibration gives a zero divisor
	task automatic test_zero_divisor;
		write_all_cal('0, '0, '0, '0);
		send_pair(20'h12345, 20'h54321);
		send_pair(20'hFFFFF, 20'h00000);
		drain();
	endtask

	// extreme calibration words, sign bits set and clear
	task automatic test_extremes;
		write_all_cal('1, '1, '1, '1);
		send_pair(20'hFFFFF, 20'hFFFFF);
		send_pair(20'h00000, 20'h00000);
		send_pair(20'hAAAAA, 20'h55555);
		drain();
		write_all_cal({16'h7FFF, 16'h8000, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'hFFFF},
			{16'h8000, 16'h7FFF, 16'h8000}, {16'h7FFF, 16'h8000, 16'h7FFF});
		send_pair(20'h55555, 20'hAAAAA);
		send_pair(20'hFFFFF, 20'h00001);
		send_pair(20'h00001, 20'hFFFFF);
		drain();
	endtask

	// random items under several calibration sets, some random, some typical
	task automatic test_random;
		for (int phase = 0; phase < 8; phase++) begin
			if (phase % 2 == 0)
				write_all_cal(rand_cal(), rand_cal(), rand_cal(), rand_cal());
			else
				write_all_cal({16'($urandom_range(0, 200)), 16'($urandom_range(20000, 27000)),
					16'($urandom_range(26000, 29000))}, {16'hFFF0 ^ 16'($urandom_range(15)),
					16'hD000 | 16'($urandom_range(4095)), 16'($urandom_range(35000, 40000))},
					{16'($urandom), 16'($urandom_range(200)), 16'($urandom_range(30000))},
					{16'($urandom), 16'($urandom), 16'($urandom)});
			gaps_on = (phase != 3);
			for (int i = 0; i < 127; i++)
				send_pair(20'($urandom), 20'($urandom));
			drain();
		end
		gaps_on = 1'b1;
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure;
		write_all_cal({16'hFC18, 16'h6A80, 16'h6E3C}, {16'h0BB8, 16'hD6A0, 16'h9470},
			{16'hFFF9, 16'h0082, 16'h2AF0}, {16'h1770, 16'hC3B4, 16'h0F00});
		hold_go = !hold_go;
		for (int i = 0; i < 120; i++)
			send_pair(20'($urandom), 20'($urandom));
		drain();
	endtask

	// receiver stall, random with a quiet stretch and one long hold
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_go_q <= 1'b0;
		end else if (hold_go != hold_go_q) begin
			hold_go_q <= hold_go;
			hold_left <= 300;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= gaps_on && ($urandom_range(99) < 24);
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		comp_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result temp %0d", $time, temperature_centi);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (temperature_centi !== e.temp) begin
					$display("%0t: temperature exp %0d got %0d", $time, e.temp,
						temperature_centi);
					errors++;
				end
				if (fine_temperature !== e.fine) begin
					$display("%0t: fine exp %0d got %0d", $time, e.fine, fine_temperature);
					errors++;
				end
				if (pressure_q24_8 !== e.press) begin
					$display("%0t: pressure exp %h got %h", $time, e.press, pressure_q24_8);
					errors++;
				end
				if (pressure_invalid !== e.inval) begin
					$display("%0t: invalid exp %b got %b", $time, e.inval, pressure_invalid);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no accepted request or result
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		gaps_on         = 1'b1;
		hold_go         = 1'b0;
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		raw_temperature = '0;
		raw_pressure    = '0;
		cfg_we          = 1'b0;
		cfg_index       = REG_CAL_TEMP;
		cfg_data        = '0;
		for (int i = 0; i < 4; i++)
			cal_words[i] = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// reset state of the registers first
		send_pair(20'h80000, 20'h40000);
		drain();
		test_typical();
		test_zero_divisor();
		test_extremes();
		test_backpressure();
		test_random();
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
